>>> hdl/hfc_pkg.sv
// Shared types and constants for the half/single float bit-pattern converter.
// No dependencies; used by hfc_convert and half_float_convert_top.
package hfc_pkg;

    localparam int WordWidth = 32;
    localparam int HalfWidth = 16;

    // Single precision limits, magnitude bits only
    localparam logic [30:0] F_MAX_HALF = 31'h477F_E000;
    localparam logic [30:0] F_INF      = 31'h7F80_0000;
    localparam logic [30:0] F_TINY     = 31'h3800_2000;

    localparam logic [14:0] H_MAX_MAG  = 15'h7BFF;
    localparam logic [14:0] H_MIN_MAG  = 15'h0001;

    // Exponent rebias between the two formats
    localparam logic [4:0] REBIAS_LOW5 = 5'd16;
    localparam logic [7:0] REBIAS      = 8'd112;

    typedef enum logic
    {
        OP_TO_HALF  = 1'b0,
        OP_TO_FLOAT = 1'b1
    } hfc_op_t;

endpackage

>>> hdl/hfc_convert.sv
// Combinational conversion between single and half float bit patterns.
// Depends on hfc_pkg.
module hfc_convert
(
    input  hfc_pkg::hfc_op_t                opcode,
    input  logic [hfc_pkg::WordWidth-1:0]   operand,
    output logic [hfc_pkg::WordWidth-1:0]   result
);
    import hfc_pkg::*;

    logic [30:0]          mag;
    logic                 f_sign;
    logic [4:0]           half_exp;
    logic [HalfWidth-1:0] half_word;
    logic [HalfWidth-1:0] h;
    logic [7:0]           float_exp;
    logic [WordWidth-1:0] float_word;

    assign mag      = operand[30:0];
    assign f_sign   = operand[31];
    assign half_exp = operand[27:23] - REBIAS_LOW5;

    always_comb
    begin
        if (mag == 31'd0)
        begin
            half_word = '0;
        end
        else if (mag > F_MAX_HALF && mag <= F_INF)
        begin
            half_word = {f_sign, H_MAX_MAG};
        end
        else if (mag < F_TINY)
        begin
            half_word = {f_sign, H_MIN_MAG};
        end
        else
        begin
            half_word = {f_sign, half_exp, operand[22:13]};
        end
    end

    assign h         = operand[HalfWidth-1:0];
    assign float_exp = {3'b000, h[14:10]} + REBIAS;

    always_comb
    begin
        if (h[14:0] == 15'd0)
        begin
            float_word = {h[15], 31'd0};
        end
        else
        begin
            float_word = {h[15], float_exp, h[9:0], 13'd0};
        end
    end

    always_comb
    begin
        case (opcode)
            OP_TO_HALF:  result = {{(WordWidth-HalfWidth){1'b0}}, half_word};
            OP_TO_FLOAT: result = float_word;
            default:     result = float_word;
        endcase
    end

endmodule

>>> hdl/half_float_convert_top.sv
// Top level of the half/single float bit-pattern converter.
// Depends on hfc_pkg and hfc_convert.
//
// Usage:
//   Input channel s_axis_*: tdata carries the operand (a float32 pattern, or a
//   half pattern in bits 15..0); tuser carries the opcode (0 = to half,
//   1 = to float). Output channel m_axis_*: tdata carries the result (half
//   pattern in bits 15..0 with bits 31..16 zero, or a float32 pattern).
//   An item moves when tvalid and tready are both high at a rising edge.
//   Path: an accepted item is held in the input register, and it is presented
//   on m_axis once it has moved into the result register.
//   Throughput: one item per cycle when not stalled; the input register feeds
//   the converter logic, whose output is held in the result register.
//   Stall: while m_axis_tready is low a full result register holds; an empty
//   input register still takes one item, and s_axis_tready is low while both
//   registers are full.
//   Reset: rst_n low clears both valid flags; no item is in flight
//   afterwards and s_axis_tready is high.
module half_float_convert_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hfc_pkg::WordWidth-1:0] s_axis_tdata,  // operand[31:0]
    input  logic                          s_axis_tuser,  // opcode[0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hfc_pkg::WordWidth-1:0] m_axis_tdata   // result[31:0]
);
    import hfc_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    hfc_op_t              in_op_reg;
    logic [WordWidth-1:0] in_operand_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WordWidth-1:0] out_data_reg;
    logic [WordWidth-1:0] conv_result;
    logic                 out_free;
    logic                 in_take;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    hfc_convert u_convert
    (
        .opcode  (in_op_reg),
        .operand (in_operand_reg),
        .result  (conv_result)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = in_valid_reg;
        end
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg      <= hfc_op_t'(s_axis_tuser);
            in_operand_reg <= s_axis_tdata;
        end
        if (out_free && in_valid_reg)
        begin
            out_data_reg <= conv_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
